// File: hw/rtl/sli_pkg.sv
// Package for the sorted list block: payload structs, opcode and status codes,
// and the control bundle that the top level broadcasts to every cell.
// No dependencies.
package sli_pkg;

  localparam int unsigned ENTRY_W   = 32;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned COUNT_W   = 5;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE_MAX = 2'd2,
    OP_REMOVE_KEY = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOKEY = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t opcode;
    entry_t  value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
    entry_t             removed_value;
    entry_t             smallest_value;
    entry_t             largest_value;
  } out_item_t;

  // Broadcast to all cells in the cycle an item is transferred.
  typedef struct packed {
    logic   ins_en;
    logic   del_min_en;
    logic   del_key_en;
    entry_t key;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/sorted_list_insert_delete.sv
// Sorted list priority queue built as a chain of DEPTH cells.
// A result is formed in order: the cells update on the input transfer, then
// the end values are gathered into the output register.
// One item at a time: the next input is taken in the cycle the pending result
// is transferred, not before. All cells of the row update together.
// Reset (synchronous, rst_n low) empties the list and drops any pending result.
module sorted_list_insert_delete #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sli_pkg::out_item_t out_data
);
  import sli_pkg::*;

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W = (CW > COUNT_W) ? CW : COUNT_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  entry_t           removed_r, removed_nxt;
  out_item_t        out_r;

  cell_ctrl_t       ctrl;
  entry_t           cell_value [DEPTH];
  entry_t           cell_last  [DEPTH];
  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] eq_vec;
  entry_t           largest;
  logic             in_fire;
  logic             full;
  logic             empty;
  logic             found;

  assign in_ready = !pend_r && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r >= CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign found    = |eq_vec;

  assign ctrl.key        = in_data.value;
  assign ctrl.ins_en     = in_fire && (in_data.opcode == OP_INSERT) && !full;
  assign ctrl.del_min_en = in_fire && (in_data.opcode == OP_REMOVE_MIN) && !empty;
  assign ctrl.del_key_en = in_fire && (in_data.opcode == OP_REMOVE_KEY) && !empty && found;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_v;
    entry_t right_v;
    logic   left_l;

    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_v = cell_value[i-1];
      assign left_l = lt_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_value[i+1];
    end

    sli_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .count       (count_r),
      .ctrl        (ctrl),
      .left_value  (left_v),
      .left_lt     (left_l),
      .right_value (right_v),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i]),
      .value       (cell_value[i]),
      .last_value  (cell_last[i])
    );
  end

  // Only the cell at count-1 drives a nonzero word, so an OR picks it out.
  always_comb begin
    largest = '0;
    for (int i = 0; i < DEPTH; i++) begin
      largest = largest | cell_last[i];
    end
  end

  always_comb begin
    status_nxt  = ST_OK;
    removed_nxt = '0;
    count_nxt   = count_r;
    case (in_data.opcode)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE_MIN: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = cell_value[0];
          count_nxt   = count_r - 1'b1;
        end
      end
      OP_REMOVE_MAX: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = largest;
          count_nxt   = count_r - 1'b1;
        end
      end
      OP_REMOVE_KEY: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOKEY;
        end else begin
          removed_nxt = in_data.value;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      pend_r <= in_fire;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
    if (pend_r) begin
      out_r.status         <= status_r;
      out_r.entry_count    <= count_r[COUNT_W-1:0];
      out_r.removed_value  <= removed_r;
      out_r.smallest_value <= (count_r == '0) ? '0 : cell_value[0];
      out_r.largest_value  <= largest;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/sli_cell.sv
// One storage cell of the sorted list: holds one value and moves it left or
// right together with its neighbors. Depends on sli_pkg.
module sli_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic               clk,
  input  logic [CNT_W-1:0]   count,
  input  sli_pkg::cell_ctrl_t ctrl,
  input  sli_pkg::entry_t    left_value,
  input  logic               left_lt,
  input  sli_pkg::entry_t    right_value,
  output logic               lt,
  output logic               eq,
  output sli_pkg::entry_t    value,
  output sli_pkg::entry_t    last_value
);
  import sli_pkg::*;

  entry_t value_r;
  entry_t value_nxt;
  logic   occ;
  logic   is_last;

  assign occ     = (count > CNT_W'(IDX));
  assign is_last = (count == CNT_W'(IDX + 1));

  assign lt = occ && (value_r < ctrl.key);
  assign eq = occ && (value_r == ctrl.key);

  assign value      = value_r;
  assign last_value = is_last ? value_r : '0;

  // The store is ascending, so every cell below the insert or delete point
  // sees lt high and keeps its value; the rest shift by one place.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins_en) begin
      if (!lt) begin
        value_nxt = left_lt ? ctrl.key : left_value;
      end
    end else if (ctrl.del_min_en) begin
      value_nxt = right_value;
    end else if (ctrl.del_key_en) begin
      if (!lt) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// File: hw/rtl/sli_checker.sv
// Port-level checks for the sorted list block, attached to the top level by
// the bind at the end of this file. Depends on sli_pkg.
module sli_port_checks #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sli_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input sli_pkg::out_item_t out_data
);
  import sli_pkg::*;

  // A stalled result holds its payload until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one item is in flight, so no input is taken while a result waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

  // A failed operation never reports a removed value.
  a_no_removed_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.removed_value == '0)
    else $error("removed value on a failed operation");

  // A successful operation leaves the ends of the list in order.
  a_ends_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OK)
    |-> out_data.smallest_value <= out_data.largest_value)
    else $error("smallest value above largest value");

  // An empty list reports zero ends (count is exact only below 32 entries).
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DEPTH < 32) && (out_data.entry_count == '0)
    |-> out_data.smallest_value == '0 && out_data.largest_value == '0)
    else $error("nonzero ends on an empty list");

endmodule

bind sorted_list_insert_delete sli_port_checks #(.DEPTH(DEPTH)) u_sli_checker (.*);

// File: tb/sv/sli_checker.sv
// Scoreboard for the sorted list block: watches both channels, keeps its own
// sorted copy of the list and compares every result transfer field by field.
// Depends on sli_pkg for the payload structs and the opcode and status codes.
module sli_checker #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sli_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sli_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 outstanding
);
  import sli_pkg::*;

  localparam int CAP = DEPTH;

  entry_t    list_vals[CAP];
  int        list_len = 0;
  out_item_t expected_results[$];
  int        n_fail = 0;

  assign fail_count  = n_fail;
  assign outstanding = expected_results.size();

  // Applies one operation to the local copy of the list and returns the
  // result the block should report for it.
  function automatic out_item_t apply_list_op(in_item_t item);
    out_item_t r;
    int        pos;
    int        i;
    r = '0;
    r.status = ST_OK;
    pos = -1;
    if (item.opcode == OP_INSERT) begin
      if (list_len >= CAP) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        // A new value goes ahead of any equal values already stored.
        while (pos < list_len && list_vals[pos] < item.value) pos++;
        for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
        list_vals[pos] = item.value;
        list_len++;
        pos = -1;
      end
    end else if (list_len == 0) begin
      r.status = ST_EMPTY;
    end else if (item.opcode == OP_REMOVE_MIN) begin
      pos = 0;
    end else if (item.opcode == OP_REMOVE_MAX) begin
      pos = list_len - 1;
    end else begin
      for (i = 0; i < list_len && pos < 0; i++) begin
        if (list_vals[i] == item.value) pos = i;
      end
      if (pos < 0) r.status = ST_NOKEY;
    end
    if (pos >= 0) begin
      r.removed_value = list_vals[pos];
      for (i = pos; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
      list_len--;
    end
    r.entry_count = list_len[COUNT_W-1:0];
    if (list_len > 0) begin
      r.smallest_value = list_vals[0];
      r.largest_value  = list_vals[list_len-1];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] expv,
                                      logic signed [31:0] actv);
    if (actv !== expv) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // The result of a transfer cannot come out in the same cycle, so the
      // oldest waiting expectation is taken before the new one is queued.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $time, out_data);
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("entry_count", want.entry_count, out_data.entry_count);
          check_field("removed_value", want.removed_value, out_data.removed_value);
          check_field("smallest_value", want.smallest_value, out_data.smallest_value);
          check_field("largest_value", want.largest_value, out_data.largest_value);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_list_op(in_data));
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the sorted list testbench: clock, reset, stimulus and the verdict.
// Instantiates sorted_list_insert_delete and the sli_checker scoreboard.
// Depends on sli_pkg.
module testbench;
  import sli_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int LIMIT    = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        outstanding;

  logic      idle_en = 1'b0;
  int        stall_left = 0;
  int        cycle_count = 0;
  entry_t    recent_vals[$];

  sorted_list_insert_delete u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sli_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("[sorted_list_insert_delete] ERROR");
      $finish;
    end
  end

  // Result side back-pressure in bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_op(opcode_t op, entry_t v);
    in_item_t item;
    item.opcode = op;
    item.value  = v;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
    end
  endtask

  function automatic entry_t pick_value();
    entry_t v;
    case ($urandom_range(0, 5))
      0, 1: v = entry_t'($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sh8000_0001;
          default: v = 32'sh7fff_fffe;
        endcase
      end
      default: v = entry_t'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int     ins_weight;
    int     roll;
    entry_t key;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: removes on an empty list, extremes, duplicates,
    // a missing key, then filling the list and inserting once more.
    send_op(OP_REMOVE_MIN, 32'sd0);
    send_op(OP_REMOVE_MAX, 32'sd0);
    send_op(OP_REMOVE_KEY, 32'sd7);
    send_op(OP_INSERT, 32'sh8000_0000);
    send_op(OP_INSERT, 32'sh7fff_ffff);
    send_op(OP_INSERT, 32'sd0);
    send_op(OP_INSERT, -32'sd1);
    send_op(OP_INSERT, 32'sd0);
    send_op(OP_REMOVE_KEY, 32'sd0);
    send_op(OP_REMOVE_KEY, 32'sd5);
    send_op(OP_REMOVE_MIN, 32'sh7fff_ffff);
    send_op(OP_REMOVE_MAX, 32'sh8000_0000);
    for (int i = 0; i < 14; i++) send_op(OP_INSERT, entry_t'($urandom));
    send_op(OP_INSERT, 32'sd1);

    // Random part in chunks; each chunk leans toward filling, draining or
    // neither, so the list keeps crossing both empty and full.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) begin
        ins_weight = $urandom_range(0, 2) * 25 + 25;
        idle_en    = (n < N_RANDOM - 300) && ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < ins_weight) begin
        send_op(OP_INSERT, pick_value());
      end else begin
        case ($urandom_range(0, 2))
          0: send_op(OP_REMOVE_MIN, entry_t'($urandom));
          1: send_op(OP_REMOVE_MAX, entry_t'($urandom));
          default: begin
            if (recent_vals.size() > 0 && $urandom_range(0, 2) != 0)
              key = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
            else
              key = pick_value();
            send_op(OP_REMOVE_KEY, key);
          end
        endcase
      end
    end
    idle_en = 1'b0;
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[sorted_list_insert_delete] OK");
    end else begin
      $display("[sorted_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule
